/* rtl/core/grid_neighbour_address_walk_core_assert.svh */
// Assertion macros for the grid neighbour address walk core.
`ifndef GRID_NEIGHBOUR_ADDRESS_WALK_CORE_ASSERT_SVH
`define GRID_NEIGHBOUR_ADDRESS_WALK_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define GNAW_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gnaw: implication check failed");

// next-cycle implication
`define GNAW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gnaw: next-cycle check failed");

`endif

/* rtl/core/gnaw_pkg.sv */
// Shared types and constants of the grid neighbour address walk core.
package gnaw_pkg;

   localparam int COORD_BITS  = 8;
   localparam int EXT_BITS    = 8;
   localparam int BORDER_BITS = 7;
   localparam int RANK_BITS   = 2;
   localparam int IDX_BITS    = 24;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RANK     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXTENT_0 = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXTENT_1 = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXTENT_2 = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BORDER   = 3'd4;

   localparam logic [RANK_BITS-1:0]   RANK_RESET   = 2'd3;
   localparam logic [EXT_BITS-1:0]    EXTENT_RESET = 8'd255;
   localparam logic [BORDER_BITS-1:0] BORDER_RESET = 7'd0;

   typedef struct packed {
      logic [RANK_BITS-1:0]   rank;
      logic [EXT_BITS-1:0]    extent_0;
      logic [EXT_BITS-1:0]    extent_1;
      logic [EXT_BITS-1:0]    extent_2;
      logic [BORDER_BITS-1:0] border;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic setup;
      logic start;
      logic advance;
      logic emit;
      logic emit_bad;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic at_centre;
      logic at_final;
      logic last_emit;
      logic slot_free;
   } sts_type;

endpackage

/* rtl/core/gnaw_ctrl.sv */
// Sequencer of the grid neighbour address walk: setup, walk and result issue.
module gnaw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  gnaw_pkg::sts_type sts,
   output gnaw_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_CENTRE = 5'b00100,
      ST_WALK   = 5'b01000,
      ST_BAD    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_CENTRE;
         end
         ST_CENTRE: begin
            cmd.start = 1'b1;
            state_in  = sts.bad ? ST_BAD : ST_WALK;
         end
         ST_WALK: begin
            if (sts.at_centre) begin
               if (sts.at_final) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end else if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (sts.last_emit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         ST_BAD: begin
            if (sts.slot_free) begin
               cmd.emit_bad = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/gnaw_dpath.sv */
// Datapath of the grid neighbour address walk: band check, index math, offsets, result beat.
module gnaw_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  gnaw_pkg::cfg_type                 cfg,
   input  gnaw_pkg::cmd_type                 cmd,
   output gnaw_pkg::sts_type                 sts,
   input  logic [gnaw_pkg::COORD_BITS-1:0]   req_coord_0,
   input  logic [gnaw_pkg::COORD_BITS-1:0]   req_coord_1,
   input  logic [gnaw_pkg::COORD_BITS-1:0]   req_coord_2,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [gnaw_pkg::IDX_BITS-1:0]     rsp_neighbour_index,
   output logic [gnaw_pkg::IDX_BITS-1:0]     rsp_centre_index,
   output logic                              rsp_is_behind,
   output logic                              rsp_is_last,
   output logic                              rsp_centre_bad
);

   localparam logic [1:0] OFF_NEG  = 2'b11;
   localparam logic [1:0] OFF_ZERO = 2'b00;
   localparam logic [1:0] OFF_POS  = 2'b01;

   // returns {bad, low neighbour exists, high neighbour exists}
   function automatic logic [2:0] band_check(input logic [7:0] c, input logic [7:0] e,
                                             input logic [6:0] b);
      logic [8:0] min_ext;
      logic [8:0] c_top;
      logic       bad;
      logic       lo_n;
      logic       hi_p;
      min_ext = {1'b0, b, 1'b0} + 9'd1;
      c_top   = {1'b0, c} + {2'b00, b} + 9'd1;
      bad     = ({1'b0, e} < min_ext) || (c < {1'b0, b}) || (c_top > {1'b0, e});
      lo_n    = c > {1'b0, b};
      hi_p    = c_top < {1'b0, e};
      return {bad, lo_n, hi_p};
   endfunction

   function automatic logic [23:0] stride_term(input logic [1:0] o, input logic [23:0] s);
      case (o)
         OFF_POS: return s;
         OFF_NEG: return (~s) + 24'd1;
         default: return 24'd0;
      endcase
   endfunction

   logic        use1, use2;
   logic [2:0]  bc0, bc1, bc2;
   logic [7:0]  c1_in, c2_in, e1_in, e2_in;
   logic [15:0] p1_in, s0_in;
   logic [16:0] row_sum;
   logic [24:0] row_prod;

   logic [7:0]  c1_ff, c2_ff, e2_ff;
   logic [15:0] p1_ff, s0_ff;
   logic [23:0] p2_ff, centre_ff;
   logic        bad_ff;
   logic [2:0]  lo_ff, hi_ff;
   logic [1:0]  off_ff [3];
   logic [1:0]  off_in [3];
   logic [1:0]  lo_val [3];
   logic [1:0]  hi_val [3];
   logic [1:0]  succ [3];
   logic        carry2, carry1;
   logic        at_final, succ_final, succ_centre;
   logic [23:0] nbr_idx;
   logic        behind;

   logic        rsp_valid_ff;
   logic [23:0] nbr_ff, ctr_ff;
   logic        behind_ff, last_ff, cbad_ff;

   always_comb begin
      use1  = cfg.rank >= 2'd2;
      use2  = cfg.rank == 2'd3;
      bc0   = band_check(req_coord_0, cfg.extent_0, cfg.border);
      bc1   = use1 ? band_check(req_coord_1, cfg.extent_1, cfg.border) : 3'b000;
      bc2   = use2 ? band_check(req_coord_2, cfg.extent_2, cfg.border) : 3'b000;
      c1_in = use1 ? req_coord_1 : 8'd0;
      c2_in = use2 ? req_coord_2 : 8'd0;
      e1_in = use1 ? cfg.extent_1 : 8'd1;
      e2_in = use2 ? cfg.extent_2 : 8'd1;
      p1_in = {8'd0, req_coord_0} * {8'd0, e1_in};
      s0_in = {8'd0, e1_in} * {8'd0, e2_in};
      off_in[0] = bc0[1] ? OFF_NEG : OFF_ZERO;
      off_in[1] = bc1[1] ? OFF_NEG : OFF_ZERO;
      off_in[2] = bc2[1] ? OFF_NEG : OFF_ZERO;
   end

   always_comb begin
      row_sum  = {1'b0, p1_ff} + {9'd0, c1_ff};
      row_prod = {8'd0, row_sum} * {17'd0, e2_ff};
   end

   always_comb begin
      for (int d = 0; d < 3; d++) begin
         lo_val[d] = lo_ff[d] ? OFF_NEG : OFF_ZERO;
         hi_val[d] = hi_ff[d] ? OFF_POS : OFF_ZERO;
      end
      carry2  = off_ff[2] == hi_val[2];
      succ[2] = carry2 ? lo_val[2] : off_ff[2] + 2'd1;
      carry1  = carry2 && (off_ff[1] == hi_val[1]);
      succ[1] = carry2 ? ((off_ff[1] == hi_val[1]) ? lo_val[1] : off_ff[1] + 2'd1)
                       : off_ff[1];
      succ[0] = carry1 ? off_ff[0] + 2'd1 : off_ff[0];
      at_final    = carry1 && (off_ff[0] == hi_val[0]);
      succ_final  = (succ[0] == hi_val[0]) && (succ[1] == hi_val[1]) &&
                    (succ[2] == hi_val[2]);
      succ_centre = (succ[0] == OFF_ZERO) && (succ[1] == OFF_ZERO) &&
                    (succ[2] == OFF_ZERO);
      nbr_idx = centre_ff + stride_term(off_ff[0], {8'd0, s0_ff}) +
                stride_term(off_ff[1], {16'd0, e2_ff}) +
                stride_term(off_ff[2], 24'd1);
      behind  = (off_ff[0] == OFF_NEG) ||
                ((off_ff[0] == OFF_ZERO) && ((off_ff[1] == OFF_NEG) ||
                 ((off_ff[1] == OFF_ZERO) && (off_ff[2] == OFF_NEG))));
      sts.bad       = bad_ff;
      sts.at_centre = (off_ff[0] == OFF_ZERO) && (off_ff[1] == OFF_ZERO) &&
                      (off_ff[2] == OFF_ZERO);
      sts.at_final  = at_final;
      sts.last_emit = at_final || (succ_centre && succ_final);
      sts.slot_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c1_ff  <= c1_in;
         c2_ff  <= c2_in;
         e2_ff  <= e2_in;
         p1_ff  <= p1_in;
         s0_ff  <= s0_in;
         bad_ff <= bc0[2] | bc1[2] | bc2[2];
         lo_ff  <= {bc2[1], bc1[1], bc0[1]};
         hi_ff  <= {bc2[0], bc1[0], bc0[0]};
         for (int d = 0; d < 3; d++) begin
            off_ff[d] <= off_in[d];
         end
      end else if (cmd.advance) begin
         for (int d = 0; d < 3; d++) begin
            off_ff[d] <= succ[d];
         end
      end
      if (cmd.setup) begin
         p2_ff <= row_prod[23:0];
      end
      if (cmd.start) begin
         centre_ff <= p2_ff + {16'd0, c2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.emit_bad) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         nbr_ff    <= nbr_idx;
         ctr_ff    <= centre_ff;
         behind_ff <= behind;
         last_ff   <= sts.last_emit;
         cbad_ff   <= 1'b0;
      end else if (cmd.emit_bad) begin
         nbr_ff    <= 24'd0;
         ctr_ff    <= centre_ff;
         behind_ff <= 1'b0;
         last_ff   <= 1'b1;
         cbad_ff   <= 1'b1;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_neighbour_index = nbr_ff;
   assign rsp_centre_index    = ctr_ff;
   assign rsp_is_behind       = behind_ff;
   assign rsp_is_last         = last_ff;
   assign rsp_centre_bad      = cbad_ff;

endmodule

/* rtl/core/grid_neighbour_address_walk_core.sv */
// Top level of the grid neighbour address walk core: registers, sequencer and datapath.
//
// Channel  Direction  Handshake              Beat contents
// req      in         req_valid/req_ready    centre coordinates coord_0..coord_2
// rsp      out        rsp_valid/rsp_ready    neighbour/centre index and flags
// csr      in         csr_valid/csr_ready    register index and write data
//
// A centre is set up in steps (accept, row product, centre add), then its
// neighbours are issued in turn through the shared offset adder, skipping the centre.
// A bad centre gives its single beat once setup and the centre add are done.
// A stalled rsp holds the walk; the next centre is taken once the walk ends.
// Reset is synchronous and restores rank 3, extents 255, border 0.
`include "grid_neighbour_address_walk_core_assert.svh"

module grid_neighbour_address_walk_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [gnaw_pkg::COORD_BITS-1:0]      req_coord_0,
   input  logic [gnaw_pkg::COORD_BITS-1:0]      req_coord_1,
   input  logic [gnaw_pkg::COORD_BITS-1:0]      req_coord_2,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [gnaw_pkg::IDX_BITS-1:0]        rsp_neighbour_index,
   output logic [gnaw_pkg::IDX_BITS-1:0]        rsp_centre_index,
   output logic                                 rsp_is_behind,
   output logic                                 rsp_is_last,
   output logic                                 rsp_centre_bad,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gnaw_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [gnaw_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   gnaw_pkg::cfg_type cfg_ff;
   gnaw_pkg::cmd_type cmd;
   gnaw_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rank     <= gnaw_pkg::RANK_RESET;
         cfg_ff.extent_0 <= gnaw_pkg::EXTENT_RESET;
         cfg_ff.extent_1 <= gnaw_pkg::EXTENT_RESET;
         cfg_ff.extent_2 <= gnaw_pkg::EXTENT_RESET;
         cfg_ff.border   <= gnaw_pkg::BORDER_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            gnaw_pkg::CSR_RANK:     cfg_ff.rank     <= csr_data[gnaw_pkg::RANK_BITS-1:0];
            gnaw_pkg::CSR_EXTENT_0: cfg_ff.extent_0 <= csr_data;
            gnaw_pkg::CSR_EXTENT_1: cfg_ff.extent_1 <= csr_data;
            gnaw_pkg::CSR_EXTENT_2: cfg_ff.extent_2 <= csr_data;
            gnaw_pkg::CSR_BORDER:   cfg_ff.border   <= csr_data[gnaw_pkg::BORDER_BITS-1:0];
            default: ;
         endcase
      end
   end

   gnaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gnaw_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_coord_0         (req_coord_0),
      .req_coord_1         (req_coord_1),
      .req_coord_2         (req_coord_2),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_centre_index    (rsp_centre_index),
      .rsp_is_behind       (rsp_is_behind),
      .rsp_is_last         (rsp_is_last),
      .rsp_centre_bad      (rsp_centre_bad)
   );

   `GNAW_ASSERT_IMPLY(a_bad_beat_form, rsp_valid && rsp_centre_bad, rsp_is_last && (rsp_neighbour_index == '0) && !rsp_is_behind)
   `GNAW_ASSERT_IMPLY(a_nbr_not_centre, rsp_valid && !rsp_centre_bad, rsp_neighbour_index != rsp_centre_index)
   `GNAW_ASSERT_IMPLY(a_behind_order, rsp_valid && !rsp_centre_bad, rsp_is_behind == (rsp_neighbour_index < rsp_centre_index))
   `GNAW_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

endmodule

/* bench/tb_grid_neighbour_address_walk_core.sv */
// Testbench of the grid neighbour address walk core: predicted neighbour walks checked per beat.
`timescale 1ns / 100ps

module tb_grid_neighbour_address_walk_core;

   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CAP     = 100000;
   localparam int PRINT_CAP     = 50;

   typedef logic [gnaw_pkg::COORD_BITS-1:0]    coord_type;
   typedef logic [gnaw_pkg::CSR_DATA_BITS-1:0] csr_data_type;

   typedef struct packed {
      logic [gnaw_pkg::IDX_BITS-1:0] neighbour_index;
      logic [gnaw_pkg::IDX_BITS-1:0] centre_index;
      logic                          is_behind;
      logic                          is_last;
      logic                          centre_bad;
   } nbr_beat_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [gnaw_pkg::COORD_BITS-1:0]    req_coord_0 = '0;
   logic [gnaw_pkg::COORD_BITS-1:0]    req_coord_1 = '0;
   logic [gnaw_pkg::COORD_BITS-1:0]    req_coord_2 = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic [gnaw_pkg::IDX_BITS-1:0]      rsp_neighbour_index;
   logic [gnaw_pkg::IDX_BITS-1:0]      rsp_centre_index;
   logic                               rsp_is_behind;
   logic                               rsp_is_last;
   logic                               rsp_centre_bad;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [gnaw_pkg::CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [gnaw_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   gnaw_pkg::cfg_type grid_cfg;
   nbr_beat_type      neighbour_q[$];
   nbr_beat_type      got_beat;
   nbr_beat_type      want_beat;
   int                err_count = 0;
   int                send_idle_pct = 0;
   int                rsp_stall_pct = 0;
   logic              rsp_hold = 1'b0;

   grid_neighbour_address_walk_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_coord_0         (req_coord_0),
      .req_coord_1         (req_coord_1),
      .req_coord_2         (req_coord_2),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_centre_index    (rsp_centre_index),
      .rsp_is_behind       (rsp_is_behind),
      .rsp_is_last         (rsp_is_last),
      .rsp_centre_bad      (rsp_centre_bad),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (err_count < PRINT_CAP)
         $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got_beat.neighbour_index = rsp_neighbour_index;
         got_beat.centre_index    = rsp_centre_index;
         got_beat.is_behind       = rsp_is_behind;
         got_beat.is_last         = rsp_is_last;
         got_beat.centre_bad      = rsp_centre_bad;
         if (neighbour_q.size() == 0) begin
            report_mismatch("unexpected beat", got_beat.neighbour_index, 0);
         end else begin
            want_beat = neighbour_q.pop_front();
            if (got_beat.neighbour_index !== want_beat.neighbour_index)
               report_mismatch("neighbour_index", got_beat.neighbour_index,
                               want_beat.neighbour_index);
            if (got_beat.centre_index !== want_beat.centre_index)
               report_mismatch("centre_index", got_beat.centre_index, want_beat.centre_index);
            if (got_beat.is_behind !== want_beat.is_behind)
               report_mismatch("is_behind", got_beat.is_behind, want_beat.is_behind);
            if (got_beat.is_last !== want_beat.is_last)
               report_mismatch("is_last", got_beat.is_last, want_beat.is_last);
            if (got_beat.centre_bad !== want_beat.centre_bad)
               report_mismatch("centre_bad", got_beat.centre_bad, want_beat.centre_bad);
         end
      end
   end

   function automatic logic [gnaw_pkg::IDX_BITS-1:0] row_major_index(
         input int unsigned a0, a1, a2, input int unsigned e1, e2);
      longint unsigned wide;
      wide = (longint'(a0) * e1 + a1) * e2 + a2;
      return wide[gnaw_pkg::IDX_BITS-1:0];
   endfunction

   task automatic predict_neighbours(input coord_type c0, c1, c2);
      int unsigned rnk;
      int unsigned ctr[3];
      int unsigned ext[3];
      int unsigned lo[3];
      int unsigned hi[3];
      int unsigned n0, n1, n2;
      int          top;
      int          d;
      logic        bad;
      logic        have_pending;
      logic [gnaw_pkg::IDX_BITS-1:0] centre;
      nbr_beat_type pending;
      rnk = (grid_cfg.rank == 0) ? 1 : grid_cfg.rank;
      ctr = '{c0, c1, c2};
      ext = '{grid_cfg.extent_0, grid_cfg.extent_1, grid_cfg.extent_2};
      bad = 1'b0;
      for (d = 0; d < 3; d++) begin
         top   = int'(ext[d]) - 1 - int'(grid_cfg.border);
         lo[d] = 0;
         hi[d] = 0;
         if (d >= rnk) begin
            ctr[d] = 0;
            ext[d] = 1;
         end else if (top < int'(grid_cfg.border) || ctr[d] < grid_cfg.border ||
                      int'(ctr[d]) > top) begin
            bad = 1'b1;
         end else begin
            lo[d] = (ctr[d] > grid_cfg.border) ? ctr[d] - 1 : ctr[d];
            hi[d] = (int'(ctr[d]) < top) ? ctr[d] + 1 : ctr[d];
         end
      end
      centre = row_major_index(ctr[0], ctr[1], ctr[2], ext[1], ext[2]);
      if (bad) begin
         pending.neighbour_index = '0;
         pending.centre_index    = centre;
         pending.is_behind       = 1'b0;
         pending.is_last         = 1'b1;
         pending.centre_bad      = 1'b1;
         neighbour_q.push_back(pending);
         return;
      end
      // hold one beat back so the final one can be tagged last
      have_pending = 1'b0;
      for (n0 = lo[0]; n0 <= hi[0]; n0++)
         for (n1 = lo[1]; n1 <= hi[1]; n1++)
            for (n2 = lo[2]; n2 <= hi[2]; n2++)
               if (!(n0 == ctr[0] && n1 == ctr[1] && n2 == ctr[2])) begin
                  if (have_pending) neighbour_q.push_back(pending);
                  pending.neighbour_index = row_major_index(n0, n1, n2, ext[1], ext[2]);
                  pending.centre_index    = centre;
                  pending.is_behind       = (n0 != ctr[0]) ? (n0 < ctr[0]) :
                                            (n1 != ctr[1]) ? (n1 < ctr[1]) : (n2 < ctr[2]);
                  pending.is_last         = 1'b0;
                  pending.centre_bad      = 1'b0;
                  have_pending            = 1'b1;
               end
      if (have_pending) begin
         pending.is_last = 1'b1;
         neighbour_q.push_back(pending);
      end
   endtask

   task automatic send_centre(input coord_type c0, c1, c2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_coord_0 <= c0;
      req_coord_1 <= c1;
      req_coord_2 <= c2;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_neighbours(c0, c1, c2);
   endtask

   task automatic write_csr(input logic [gnaw_pkg::CSR_IDX_BITS-1:0] idx,
                            input csr_data_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         gnaw_pkg::CSR_RANK:     grid_cfg.rank     = data[gnaw_pkg::RANK_BITS-1:0];
         gnaw_pkg::CSR_EXTENT_0: grid_cfg.extent_0 = data[gnaw_pkg::EXT_BITS-1:0];
         gnaw_pkg::CSR_EXTENT_1: grid_cfg.extent_1 = data[gnaw_pkg::EXT_BITS-1:0];
         gnaw_pkg::CSR_EXTENT_2: grid_cfg.extent_2 = data[gnaw_pkg::EXT_BITS-1:0];
         gnaw_pkg::CSR_BORDER:   grid_cfg.border   = data[gnaw_pkg::BORDER_BITS-1:0];
         default: ;
      endcase
   endtask

   // drain all expected beats, then let a walk with no beats run out
   task automatic wait_idle();
      int spin;
      spin = 0;
      req_valid <= 1'b0;
      while (neighbour_q.size() != 0 && spin < DRAIN_CAP) begin
         @(posedge clock);
         spin++;
      end
      if (neighbour_q.size() != 0) begin
         report_mismatch("missing beats", neighbour_q.size(), 0);
         neighbour_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input csr_data_type rank_data, e0, e1, e2,
                               input csr_data_type border_data);
      wait_idle();
      write_csr(gnaw_pkg::CSR_RANK, rank_data);
      write_csr(gnaw_pkg::CSR_EXTENT_0, e0);
      write_csr(gnaw_pkg::CSR_EXTENT_1, e1);
      write_csr(gnaw_pkg::CSR_EXTENT_2, e2);
      write_csr(gnaw_pkg::CSR_BORDER, border_data);
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int stall_pct);
      send_idle_pct = sender_pct;
      rsp_stall_pct <= stall_pct;
   endtask

   function automatic csr_data_type pick_extent();
      case ($urandom_range(15))
         0:       return 8'd0;
         1, 2:    return 8'd255;
         default: return csr_data_type'($urandom_range(9, 1));
      endcase
   endfunction

   // mostly in-band coordinates with the band edges favored, some noise
   function automatic coord_type pick_coord(input int d);
      int unsigned rnk;
      int unsigned ext;
      int          lo;
      int          hi;
      rnk = (grid_cfg.rank == 0) ? 1 : grid_cfg.rank;
      ext = (d == 0) ? grid_cfg.extent_0 : (d == 1) ? grid_cfg.extent_1 : grid_cfg.extent_2;
      lo  = grid_cfg.border;
      hi  = int'(ext) - 1 - lo;
      if (d >= rnk || hi < lo || $urandom_range(5) == 0)
         return coord_type'($urandom_range(255));
      case ($urandom_range(3))
         0:       return coord_type'(lo);
         1:       return coord_type'(hi);
         default: return coord_type'($urandom_range(hi, lo));
      endcase
   endfunction

   task automatic random_geometry();
      set_geometry(csr_data_type'($urandom_range(255)), pick_extent(), pick_extent(),
                   pick_extent(),
                   csr_data_type'(($urandom_range(7) == 0) ? $urandom_range(255) :
                                                            $urandom_range(2)));
   endtask

   task automatic test_reset_corners();
      send_centre(8'd0, 8'd0, 8'd0);
      send_centre(8'd254, 8'd254, 8'd254);
      send_centre(8'd0, 8'd254, 8'd127);
      send_centre(8'd100, 8'd37, 8'd200);
      send_centre(8'd255, 8'd10, 8'd10);
      send_centre(8'd10, 8'd10, 8'd255);
   endtask

   task automatic test_special_cases();
      // rank 1, band 1..3, unused coordinates ignored
      set_geometry(8'd1, 8'd5, 8'd255, 8'd255, 8'd1);
      send_centre(8'd1, 8'd255, 8'd0);
      send_centre(8'd3, 8'd0, 8'd255);
      send_centre(8'd2, 8'd170, 8'd85);
      send_centre(8'd0, 8'd2, 8'd2);
      send_centre(8'd4, 8'd2, 8'd2);
      // one-wide band in both dimensions: no neighbours
      set_geometry(8'd2, 8'd3, 8'd3, 8'd255, 8'd1);
      send_centre(8'd1, 8'd1, 8'd0);
      send_centre(8'd1, 8'd2, 8'd9);
      // rank 0 acts as rank 1
      set_geometry(8'd0, 8'd1, 8'd255, 8'd255, 8'd0);
      send_centre(8'd0, 8'd77, 8'd200);
      send_centre(8'd1, 8'd0, 8'd0);
      // zero extent
      set_geometry(8'd3, 8'd255, 8'd0, 8'd255, 8'd0);
      send_centre(8'd0, 8'd0, 8'd0);
      send_centre(8'd3, 8'd3, 8'd3);
      // widest border, register bits above the field set
      set_geometry(8'hFF, 8'd255, 8'd255, 8'd255, 8'hFF);
      send_centre(8'd127, 8'd127, 8'd127);
      send_centre(8'd126, 8'd127, 8'd127);
      send_centre(8'd128, 8'd127, 8'd127);
      // empty band
      set_geometry(8'd2, 8'd4, 8'd6, 8'd1, 8'd2);
      send_centre(8'd2, 8'd2, 8'd0);
   endtask

   task automatic test_backpressure();
      int k;
      set_geometry(8'd3, 8'd255, 8'd255, 8'd255, 8'd0);
      set_idling(0, 0);
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         for (k = 0; k < 12; k++)
            send_centre(coord_type'($urandom_range(253, 1)), coord_type'($urandom_range(253, 1)),
                        coord_type'($urandom_range(253, 1)));
      join
   endtask

   task automatic test_random_walks(input int sender_pct, input int stall_pct, input int count);
      int k;
      set_idling(sender_pct, stall_pct);
      for (k = 0; k < count; k++) begin
         if (k % 20 == 0) random_geometry();
         send_centre(pick_coord(0), pick_coord(1), pick_coord(2));
      end
   endtask

   initial begin
      grid_cfg = '{gnaw_pkg::RANK_RESET, gnaw_pkg::EXTENT_RESET, gnaw_pkg::EXTENT_RESET,
                   gnaw_pkg::EXTENT_RESET, gnaw_pkg::BORDER_RESET};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_corners();
      test_special_cases();
      test_backpressure();
      test_random_walks(0, 0, 32);
      test_random_walks(82, 0, 32);
      test_random_walks(0, 82, 32);
      test_random_walks(22, 22, 32);
      wait_idle();
      if (err_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
